[rtl/hdbf_pkg.sv]
// ----------------------------------------------------------------------------
// hdbf_pkg
// Shared constants, types and arithmetic helpers for the binaural FIR.
// ----------------------------------------------------------------------------
package hdbf_pkg;

  localparam int unsigned MaxTaps      = 512;
  localparam int unsigned MaxHarmonics = 16;
  localparam int unsigned TapW         = $clog2(MaxTaps);
  localparam int unsigned HarmW        = $clog2(MaxHarmonics);
  localparam int unsigned AddrW        = TapW + HarmW;
  localparam int unsigned RamDepth     = MaxTaps * MaxHarmonics;
  localparam int unsigned SampleW      = 24;
  localparam int unsigned ProdW        = 2 * SampleW;
  localparam int unsigned AccW         = ProdW + AddrW + 1;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned HarmCntW     = 5;
  localparam int unsigned TapCntW      = 10;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [CfgIdxW-1:0] CfgHarmonics = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTaps      = CfgIdxW'(1);

  localparam logic [HarmCntW-1:0] HarmReset = HarmCntW'(1);
  localparam logic [TapCntW-1:0]  TapReset  = TapCntW'(200);

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT,
    CMD_LOAD_RIGHT,
    CMD_SAMPLE,
    CMD_SAMPLE_EOF
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic [TapW-1:0]           tap;
    logic [HarmW-1:0]          harmonic;
    logic signed [SampleW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [HarmCntW-1:0] harmonics;
    logic [TapCntW-1:0]  taps;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT,
    ST_CLEAR
  } back_state_e;

  // Round half up at bit 20, then clamp to 24-bit signed.
  function automatic logic signed [SampleW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0]    v;
    logic signed [AccW-21:0]   q;
    logic signed [SampleW-1:0] r;
    v = acc + AccW'(1 << 19);
    q = (AccW-20)'(v >>> 20);
    if (q > (AccW-20)'(8388607)) begin
      r = 24'sh7FFFFF;
    end else if (q < -(AccW-20)'(8388608)) begin
      r = 24'sh800000;
    end else begin
      r = q[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/hdbf_if.sv]
// ----------------------------------------------------------------------------
// hdbf_if
// Request channels of the binaural FIR: input items, results, register writes.
// ----------------------------------------------------------------------------
interface hdbf_item_if import hdbf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic                      ear;
  logic [TapW-1:0]           tap;
  logic [HarmW-1:0]          harmonic;
  logic signed [SampleW-1:0] value;
  logic                      end_of_frame;

  modport source (output valid, operation, ear, tap, harmonic, value, end_of_frame,
                  input ready);
  modport sink   (input valid, operation, ear, tap, harmonic, value, end_of_frame,
                  output ready);
endinterface

interface hdbf_result_if import hdbf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_sample;
  logic signed [SampleW-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface hdbf_cfg_if import hdbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/hdbf_ram.sv]
// ----------------------------------------------------------------------------
// hdbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hdbf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/hdbf_queue.sv]
// ----------------------------------------------------------------------------
// hdbf_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module hdbf_queue import hdbf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/hdbf_front.sv]
// ----------------------------------------------------------------------------
// hdbf_front
// Accepts input requests and turns them into back-end commands.
// ----------------------------------------------------------------------------
module hdbf_front import hdbf_pkg::*; (
  hdbf_item_if.sink in_i,
  input  logic      full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.tap      = in_i.tap;
    cmd_o.harmonic = in_i.harmonic;
    cmd_o.value    = in_i.value;
    if (in_i.operation) begin
      cmd_o.kind = in_i.end_of_frame ? CMD_SAMPLE_EOF : CMD_SAMPLE;
    end else begin
      cmd_o.kind = in_i.ear ? CMD_LOAD_RIGHT : CMD_LOAD_LEFT;
    end
  end

endmodule

[rtl/hdbf_back.sv]
// ----------------------------------------------------------------------------
// hdbf_back
// Executes commands: coefficient writes, history writes and the MAC sweep.
// ----------------------------------------------------------------------------
module hdbf_back import hdbf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      empty_i,
  input  cmd_t                      cmd_i,
  output logic                      pop_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic signed [SampleW-1:0] left_o,
  output logic signed [SampleW-1:0] right_o
);

  back_state_e state_q, state_d;

  logic [AddrW-1:0]   clr_q, clr_d;
  logic [TapW-1:0]    time_q, time_d;
  logic [TapW-1:0]    tap_q, tap_d;
  logic [HarmW-1:0]   harm_q, harm_d;
  logic               rd_v_q, mul_v_q, issue;
  logic               out_v_q;
  logic               out_free, out_load, acc_clr;
  logic [TapCntW-1:0] ntaps;
  logic [HarmCntW-1:0] nharm;
  logic               last_harm, last_tap;

  logic                   cl_we, cr_we, h_we;
  logic [AddrW-1:0]       cl_wa, cr_wa, h_wa, c_ra, h_ra;
  logic [SampleW-1:0]     cl_wd, cr_wd, h_wd, cl_rd, cr_rd, h_rd;
  logic signed [ProdW-1:0] prod_l_q, prod_r_q;
  logic signed [AccW-1:0]  acc_l_q, acc_r_q;

  assign ntaps = (cfg_i.taps > TapCntW'(MaxTaps)) ? TapCntW'(MaxTaps) : cfg_i.taps;
  assign nharm = (cfg_i.harmonics > HarmCntW'(MaxHarmonics)) ?
                 HarmCntW'(MaxHarmonics) : cfg_i.harmonics;

  assign last_harm = ({1'b0, harm_q} == nharm - 1'b1);
  assign last_tap  = ({1'b0, tap_q} == ntaps - 1'b1);
  assign out_free  = !out_v_q || res_ready_i;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (clr_q == AddrW'(RamDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop_o && cmd_i.kind == CMD_SAMPLE_EOF) begin
          state_d = (ntaps == '0 || nharm == '0) ? ST_DRAIN : ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_harm && last_tap) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v_q && !mul_v_q) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (clr_q[HarmW-1:0] == HarmW'(MaxHarmonics - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Outputs and counters
  always_comb begin
    clr_d    = clr_q;
    time_d   = time_q;
    tap_d    = tap_q;
    harm_d   = harm_q;
    issue    = 1'b0;
    out_load = 1'b0;
    acc_clr  = 1'b0;
    cl_we = 1'b0; cl_wa = {TapW'(cmd_i.tap), cmd_i.harmonic}; cl_wd = cmd_i.value;
    cr_we = 1'b0; cr_wa = {TapW'(cmd_i.tap), cmd_i.harmonic}; cr_wd = cmd_i.value;
    h_we  = 1'b0; h_wa  = {time_q, cmd_i.harmonic};          h_wd  = cmd_i.value;
    c_ra  = {tap_q, harm_q};
    h_ra  = {TapW'(time_q - tap_q), harm_q};
    case (state_q)
      ST_INIT: begin
        cl_we = 1'b1; cl_wa = clr_q; cl_wd = '0;
        cr_we = 1'b1; cr_wa = clr_q; cr_wd = '0;
        h_we  = 1'b1; h_wa  = clr_q; h_wd  = '0;
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (pop_o) begin
          case (cmd_i.kind)
            CMD_LOAD_LEFT:  cl_we = 1'b1;
            CMD_LOAD_RIGHT: cr_we = 1'b1;
            CMD_SAMPLE:     h_we  = 1'b1;
            CMD_SAMPLE_EOF: begin
              h_we    = 1'b1;
              acc_clr = 1'b1;
              tap_d   = '0;
              harm_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (last_harm) begin
          harm_d = '0;
          tap_d  = tap_q + 1'b1;
        end else begin
          harm_d = harm_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          time_d   = time_q + 1'b1;
          clr_d    = '0;
        end
      end
      ST_CLEAR: begin
        // Zero the column of the frame that just opened.
        h_we  = 1'b1;
        h_wa  = {time_q, clr_q[HarmW-1:0]};
        h_wd  = '0;
        clr_d = clr_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_q   <= '0;
      time_q  <= '0;
      tap_q   <= '0;
      harm_q  <= '0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      time_q  <= time_d;
      tap_q   <= tap_d;
      harm_q  <= harm_d;
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
      if (out_load) out_v_q <= 1'b1;
      else if (res_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_l_q <= $signed(cl_rd) * $signed(h_rd);
      prod_r_q <= $signed(cr_rd) * $signed(h_rd);
    end
    if (acc_clr) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (mul_v_q) begin
      acc_l_q <= acc_l_q + AccW'(prod_l_q);
      acc_r_q <= acc_r_q + AccW'(prod_r_q);
    end
    if (out_load) begin
      left_o  <= round_sat(acc_l_q);
      right_o <= round_sat(acc_r_q);
    end
  end

  assign res_valid_o = out_v_q;

  hdbf_ram #(.Width(SampleW), .Depth(RamDepth)) u_coef_left (
    .clk_i, .we_i(cl_we), .waddr_i(cl_wa), .wdata_i(cl_wd), .raddr_i(c_ra), .rdata_o(cl_rd)
  );
  hdbf_ram #(.Width(SampleW), .Depth(RamDepth)) u_coef_right (
    .clk_i, .we_i(cr_we), .waddr_i(cr_wa), .wdata_i(cr_wd), .raddr_i(c_ra), .rdata_o(cr_rd)
  );
  hdbf_ram #(.Width(SampleW), .Depth(RamDepth)) u_history (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd)
  );

endmodule

[rtl/harmonic_domain_binaural_fir.sv]
// Coefficient loads and plain samples each take one RAM write in the back end. A
// frame-closing sample runs a left and a right MAC over taps*harmonics products,
// drains the pipeline, registers the result once the output is free and zeroes the
// 16 entries of the new column. A four-entry command queue lets input requests arrive
// while a frame computes. After reset a clearing pass over 8192 addresses zeroes the
// coefficient and history RAMs; input requests queue but do not execute until it ends.
// ----------------------------------------------------------------------------
// harmonic_domain_binaural_fir
// Two-ear FIR over circular-harmonic frames with saturated 24-bit outputs.
// ----------------------------------------------------------------------------
module harmonic_domain_binaural_fir import hdbf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdbf_item_if.sink   in_i,
  hdbf_result_if.source out_o,
  hdbf_cfg_if.sink    cfg_i
);

  cfg_t cfg_q;
  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.harmonics <= HarmReset;
      cfg_q.taps      <= TapReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgHarmonics) cfg_q.harmonics <= cfg_i.data[HarmCntW-1:0];
      if (cfg_i.index == CfgTaps)      cfg_q.taps      <= cfg_i.data[TapCntW-1:0];
    end
  end

  hdbf_front u_front (
    .in_i, .full_i(full), .push_o(push), .cmd_o(push_cmd)
  );

  hdbf_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_cmd), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(pop_cmd)
  );

  hdbf_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .cmd_i(pop_cmd), .pop_o(pop),
    .res_valid_o(out_o.valid), .res_ready_i(out_o.ready),
    .left_o(out_o.left_sample), .right_o(out_o.right_sample)
  );

endmodule
